// ===== design/sdbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdbc_pkg
// Byte functions for the keyed substitution-diffusion block cipher:
// keyed S-box and its inverse, diffusion layer, byte rotation and MAC fold.
// ----------------------------------------------------------------------------
package sdbc_pkg;

  localparam int NBytes = 16;

  typedef logic [7:0]   byte_t;
  typedef logic [127:0] block_t;

  localparam byte_t SboxMul   = 8'd179;
  localparam byte_t SboxAdd   = 8'd17;
  localparam byte_t SboxMulInv = 8'd123;
  localparam byte_t DiffMul   = 8'd31;
  localparam byte_t DiffAdd   = 8'd7;
  localparam byte_t DiffMulInv = 8'd223;
  localparam logic [3:0] RotStep = 4'd6;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  function automatic byte_t lin_fwd(input byte_t y);
    lin_fwd = y ^ (y >> 4) ^ (y << 3);
  endfunction

  function automatic byte_t lin_inv(input byte_t z);
    logic y0, y1, y2, y3, y4, y5, y6, y7;
    y7 = z[0] ^ z[1] ^ z[2] ^ z[3] ^ z[4] ^ z[5] ^ z[6];
    y4 = z[7] ^ y7;
    y1 = z[4] ^ y4;
    y5 = z[1] ^ y1;
    y2 = z[5] ^ y5;
    y6 = z[2] ^ y2;
    y3 = z[6] ^ y6;
    y0 = z[0] ^ y4;
    lin_inv = {y7, y6, y5, y4, y3, y2, y1, y0};
  endfunction

  function automatic byte_t sbox(input byte_t x, input byte_t k);
    byte_t y;
    y = {x[4:0], x[7:5]} ^ k;
    y = byte_t'(y * SboxMul + SboxAdd);
    sbox = lin_fwd(y);
  endfunction

  function automatic byte_t sbox_inv(input byte_t z, input byte_t k);
    byte_t y;
    y = lin_inv(z);
    y = byte_t'((y - SboxAdd) * SboxMulInv);
    y = y ^ k;
    sbox_inv = {y[2:0], y[7:3]};
  endfunction

  // prefix xor across the block, then affine byte map
  function automatic block_t diffuse(input block_t b);
    block_t r;
    byte_t  p;
    p = 8'd0;
    for (int i = 0; i < NBytes; i++) begin
      p = p ^ b[8*i +: 8];
      r[8*i +: 8] = byte_t'(p * DiffMul + DiffAdd);
    end
    diffuse = r;
  endfunction

  function automatic block_t undiffuse(input block_t b);
    block_t u, r;
    for (int i = 0; i < NBytes; i++) begin
      u[8*i +: 8] = byte_t'((b[8*i +: 8] - DiffAdd) * DiffMulInv);
    end
    r[7:0] = u[7:0];
    for (int i = 1; i < NBytes; i++) begin
      r[8*i +: 8] = u[8*i +: 8] ^ u[8*(i-1) +: 8];
    end
    undiffuse = r;
  endfunction

  // out byte i takes in byte (i + amt) mod 16
  function automatic block_t rot_bytes(input block_t b, input logic [3:0] amt);
    block_t     r;
    logic [3:0] idx;
    for (int i = 0; i < NBytes; i++) begin
      idx = 4'(i) + amt;
      r[8*i +: 8] = b[8*idx +: 8];
    end
    rot_bytes = r;
  endfunction

  function automatic logic [31:0] mac_fold(input logic [31:0] mac, input block_t b);
    logic [31:0] m;
    m = mac;
    for (int i = 0; i < NBytes; i++) begin
      m = {m[30:0], 1'b0} ^ {24'd0, b[8*i +: 8]};
    end
    mac_fold = m;
  endfunction

endpackage

// ===== design/sbox_diffuse_block_cipher_cbc.sv =====
// ----------------------------------------------------------------------------
// sbox_diffuse_block_cipher_cbc
// Chained 16-byte block cipher with keyed S-box rounds and running MAC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries op, block_lo, block_hi and
//   first_block; an item is taken when in_valid is high and in_stall low.
//   Output channel (out_valid / out_stall) carries result_lo, result_hi and
//   mac_value from an output register; a stalled result holds.
//   Config port (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready;
//   indexes past the register list are ignored.
// Timing:
//   Round keys sit in a NUM_ROUNDS-entry memory with a registered read port.
//   After reset and after every config write to a listed register the key
//   schedule refills that memory, one round per cycle, with in_stall high.
//   A block runs one round per cycle over a single round unit fed from the
//   key memory; in_stall stays high until the block returns to idle, so a
//   new item is taken only after the previous one has finished. A new item is
//   accepted while the previous result still waits; the block then holds its
//   finished result until the output register frees up.
//   Reset clears the chaining block, the MAC and all config registers.
// ----------------------------------------------------------------------------
module sbox_diffuse_block_cipher_cbc
  import sdbc_pkg::*;
#(
  parameter int NUM_ROUNDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [63:0] block_lo,
  input  logic [63:0] block_hi,
  input  logic        first_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_lo,
  output logic [63:0] result_hi,
  output logic [31:0] mac_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int RW = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
  localparam logic [RW-1:0] LastRound = RW'(NUM_ROUNDS - 1);

  localparam logic [2:0] StDinit  = 3'd0;
  localparam logic [2:0] StDerive = 3'd1;
  localparam logic [2:0] StIdle   = 3'd2;
  localparam logic [2:0] StRun    = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  localparam logic [7:0] RegKey0 = 8'd0;
  localparam logic [7:0] RegKey1 = 8'd1;
  localparam logic [7:0] RegKey2 = 8'd2;
  localparam logic [7:0] RegKey3 = 8'd3;
  localparam logic [7:0] RegRcLo = 8'd4;
  localparam logic [7:0] RegRcHi = 8'd5;
  localparam logic [7:0] RegIvLo = 8'd6;
  localparam logic [7:0] RegIvHi = 8'd7;

  logic [63:0]  key_word0, key_word1, key_word2, key_word3;
  logic [63:0]  round_const_lo, round_const_hi, init_vector_lo, init_vector_hi;
  logic [255:0] key_all;
  block_t       rc_all;

  logic [2:0]    state;
  logic [RW-1:0] cnt;
  logic          op_q;
  block_t        acc, acc_next;
  block_t        rk_new;
  block_t        blk, blk_next;
  block_t        saved_in;
  block_t        chain;
  logic [31:0]   mac;
  logic [3:0]    rot;

  block_t        rk_mem [NUM_ROUNDS];
  block_t        rk_q;
  logic          rd_en;
  logic [RW-1:0] rd_addr;

  block_t        in_blk, chain_eff, enc_tmp, dec_tmp, fin_blk;
  logic [31:0]   mac_eff, fin_mac;
  logic [3:0]    rot_eff;
  logic          accept, finish;

  assign key_all   = {key_word3, key_word2, key_word1, key_word0};
  assign rc_all    = {round_const_hi, round_const_lo};
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != StIdle);
  assign accept    = in_valid && !in_stall;
  assign finish    = (state == StDone) && (!out_valid || !out_stall);

  // key schedule round
  always_comb begin
    block_t     a;
    logic [4:0] r5;
    logic [4:0] kidx;
    logic [4:0] xidx;
    a  = acc;
    r5 = 5'(cnt);
    a[7:0] = a[7:0] ^ rc_all[8*r5[3:0] +: 8];
    for (int i = 0; i < NBytes; i++) begin
      kidx = r5 + 5'(i);
      xidx = {r5[0], 4'(i)};
      rk_new[8*i +: 8] = sbox(a[8*i +: 8] ^ key_all[8*xidx +: 8], key_all[8*kidx +: 8]);
    end
    acc_next = diffuse(a) ^ rk_new;
  end

  // cipher round, chaining setup and final result with MAC update
  always_comb begin
    block_t t;
    in_blk    = {block_hi, block_lo};
    chain_eff = first_block ? {init_vector_hi, init_vector_lo} : chain;
    mac_eff   = first_block ? 32'd0 : mac;
    rot_eff   = 4'(chain_eff[3:0] * RotStep);
    if (op_q == OpEncrypt) begin
      t = blk;
      for (int i = 0; i < NBytes; i++) begin
        t[8*i +: 8] = sbox(t[8*i +: 8], rk_q[8*i +: 8]);
      end
      blk_next = diffuse(t) ^ rk_q;
    end else begin
      t = undiffuse(blk ^ rk_q);
      for (int i = 0; i < NBytes; i++) begin
        t[8*i +: 8] = sbox_inv(t[8*i +: 8], rk_q[8*i +: 8]);
      end
      blk_next = t;
    end
    enc_tmp = rot_bytes(blk, rot);
    dec_tmp = blk ^ chain;
    fin_blk = (op_q == OpEncrypt) ? enc_tmp : dec_tmp;
    fin_mac = (op_q == OpEncrypt) ? mac_fold(mac, enc_tmp) : mac;
  end

  // round key memory read: first round on accept, next round while running
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (accept) begin
      rd_en   = 1'b1;
      rd_addr = (op == OpEncrypt) ? '0 : LastRound;
    end else if (state == StRun && cnt != LastRound) begin
      rd_en   = 1'b1;
      rd_addr = (op_q == OpEncrypt) ? RW'(cnt + 1'b1) : RW'(LastRound - cnt - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == StDerive) begin
      rk_mem[cnt] <= rk_new;
    end
    if (rd_en) begin
      rk_q <= rk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= StDinit;
      cnt            <= '0;
      key_word0      <= '0;
      key_word1      <= '0;
      key_word2      <= '0;
      key_word3      <= '0;
      round_const_lo <= '0;
      round_const_hi <= '0;
      init_vector_lo <= '0;
      init_vector_hi <= '0;
      chain          <= '0;
      mac            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegKey0: key_word0      <= cfg_data;
          RegKey1: key_word1      <= cfg_data;
          RegKey2: key_word2      <= cfg_data;
          RegKey3: key_word3      <= cfg_data;
          RegRcLo: round_const_lo <= cfg_data;
          RegRcHi: round_const_hi <= cfg_data;
          RegIvLo: init_vector_lo <= cfg_data;
          RegIvHi: init_vector_hi <= cfg_data;
          default: ;
        endcase
      end
      // config writes to the listed registers restart the key schedule
      if (cfg_valid && cfg_ready && cfg_index <= RegIvHi) begin
        state <= StDinit;
      end else begin
        unique case (state)
          StDinit: begin
            acc   <= key_all[127:0] ^ key_all[255:128];
            cnt   <= '0;
            state <= StDerive;
          end
          StDerive: begin
            acc <= acc_next;
            cnt <= RW'(cnt + 1'b1);
            if (cnt == LastRound) begin
              state <= StIdle;
            end
          end
          StIdle: begin
            if (accept) begin
              op_q     <= op;
              cnt      <= '0;
              rot      <= rot_eff;
              chain    <= chain_eff;
              saved_in <= in_blk;
              if (op == OpEncrypt) begin
                blk <= in_blk ^ chain_eff;
                mac <= mac_eff;
              end else begin
                blk <= rot_bytes(in_blk, 4'd0 - rot_eff);
                mac <= mac_fold(mac_eff, in_blk);
              end
              state <= StRun;
            end
          end
          StRun: begin
            blk <= blk_next;
            cnt <= RW'(cnt + 1'b1);
            if (cnt == LastRound) begin
              state <= StDone;
            end
          end
          StDone: begin
            if (finish) begin
              result_lo <= fin_blk[63:0];
              result_hi <= fin_blk[127:64];
              mac_value <= fin_mac;
              mac       <= fin_mac;
              chain     <= (op_q == OpEncrypt) ? enc_tmp : saved_in;
              state     <= StIdle;
            end
          end
          default: state <= StDinit;
        endcase
      end
    end
  end

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_valid |=> state == StRun)
    else $error("accepted item did not start rounds");

  a_last_round_done: assert property (@(posedge clk) disable iff (rst)
    state == StRun && cnt == LastRound && !cfg_valid |=> state == StDone)
    else $error("round sequence did not end after last round");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid && state != StDone)
    else $error("finished block not presented");

  a_no_accept_during_schedule: assert property (@(posedge clk) disable iff (rst)
    (state == StDinit || state == StDerive) |-> !accept)
    else $error("item accepted while key schedule runs");

endmodule
